/* rtl/core/wes_pkg.sv */
// Package for the warm-up enrichment scaler: field widths, table breakpoints,
// the divide-by-100 reciprocal and the shared pipeline types.
// No dependencies.
`default_nettype none

package wes_pkg;

  localparam int TEMP_W = 9;
  localparam int PW_W   = 16;
  localparam int PCT_W  = 8;
  localparam int PROD_W = PW_W + PCT_W;

  // Reciprocal of 100: floor(x / 100) == (x * RECIP_M) >> RECIP_SH for all x < 2**24.
  localparam int RECIP_SH = 31;
  localparam int RECIP_W  = 25;
  localparam logic [RECIP_W-1:0] RECIP_M = 25'd21474837;
  localparam int SCALED_W = PROD_W + RECIP_W;
  localparam int QUOT_W   = SCALED_W - RECIP_SH;

  // Temperature breakpoints in degrees C.
  localparam logic signed [TEMP_W-1:0] T_K0 = -9'sd10;
  localparam logic signed [TEMP_W-1:0] T_K1 = 9'sd0;
  localparam logic signed [TEMP_W-1:0] T_K2 = 9'sd10;
  localparam logic signed [TEMP_W-1:0] T_K3 = 9'sd20;
  localparam logic signed [TEMP_W-1:0] T_K4 = 9'sd30;
  localparam logic signed [TEMP_W-1:0] T_K5 = 9'sd40;
  localparam logic signed [TEMP_W-1:0] T_K6 = 9'sd60;
  localparam logic signed [TEMP_W-1:0] T_K7 = 9'sd80;

  // Enrichment percentages at the breakpoints.
  localparam logic [PCT_W-1:0] P_K0 = 8'd180;
  localparam logic [PCT_W-1:0] P_K1 = 8'd160;
  localparam logic [PCT_W-1:0] P_K2 = 8'd145;
  localparam logic [PCT_W-1:0] P_K3 = 8'd130;
  localparam logic [PCT_W-1:0] P_K4 = 8'd120;
  localparam logic [PCT_W-1:0] P_K5 = 8'd110;
  localparam logic [PCT_W-1:0] P_K6 = 8'd105;
  localparam logic [PCT_W-1:0] P_K7 = 8'd100;

  localparam logic [PW_W-1:0] PW_MAX = 16'hFFFF;

  // Segment slope classes: the drop per degree is 2, 3/2, 1 or 1/4, or flat at an end.
  typedef enum logic [2:0] {
    SEG_FLAT  = 3'd0,
    SEG_X2    = 3'd1,
    SEG_X3H   = 3'd2,
    SEG_X1    = 3'd3,
    SEG_QUART = 3'd4
  } seg_t;

  typedef struct packed {
    logic [PW_W-1:0]     width;
    logic [PCT_W-1:0]    pct;
    logic                sat;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/wes_pct_calc.sv */
// Piecewise-linear lookup of the enrichment percentage from coolant temperature.
// Depends on wes_pkg.
`default_nettype none

module wes_pct_calc (
  input  wire logic signed [wes_pkg::TEMP_W-1:0] temp,
  output logic [wes_pkg::PCT_W-1:0]              pct
);

  wes_pkg::seg_t                         seg;
  logic signed [wes_pkg::TEMP_W-1:0]     knot;
  logic signed [wes_pkg::TEMP_W-1:0]     diff;
  logic [wes_pkg::PCT_W-1:0]             pbase;
  logic [4:0]                            off;
  logic [5:0]                            q;
  logic [6:0]                            off3;

  always_comb begin
    seg   = wes_pkg::SEG_FLAT;
    knot  = wes_pkg::T_K0;
    pbase = wes_pkg::P_K7;
    priority if (temp <= wes_pkg::T_K0) begin
      pbase = wes_pkg::P_K0;
    end else if (temp < wes_pkg::T_K1) begin
      seg = wes_pkg::SEG_X2;    knot = wes_pkg::T_K0; pbase = wes_pkg::P_K0;
    end else if (temp < wes_pkg::T_K2) begin
      seg = wes_pkg::SEG_X3H;   knot = wes_pkg::T_K1; pbase = wes_pkg::P_K1;
    end else if (temp < wes_pkg::T_K3) begin
      seg = wes_pkg::SEG_X3H;   knot = wes_pkg::T_K2; pbase = wes_pkg::P_K2;
    end else if (temp < wes_pkg::T_K4) begin
      seg = wes_pkg::SEG_X1;    knot = wes_pkg::T_K3; pbase = wes_pkg::P_K3;
    end else if (temp < wes_pkg::T_K5) begin
      seg = wes_pkg::SEG_X1;    knot = wes_pkg::T_K4; pbase = wes_pkg::P_K4;
    end else if (temp < wes_pkg::T_K6) begin
      seg = wes_pkg::SEG_QUART; knot = wes_pkg::T_K5; pbase = wes_pkg::P_K5;
    end else if (temp < wes_pkg::T_K7) begin
      seg = wes_pkg::SEG_QUART; knot = wes_pkg::T_K6; pbase = wes_pkg::P_K6;
    end else begin
      pbase = wes_pkg::P_K7;
    end
  end

  // Offsets into a segment are below 20, so five bits hold them.
  assign diff = temp - knot;
  assign off  = diff[4:0];
  assign off3 = {2'b00, off} + {1'b0, off, 1'b0};

  // Every segment descends and the offset is non-negative, so truncation is a floor.
  always_comb begin
    unique case (seg)
      wes_pkg::SEG_FLAT:  q = 6'd0;
      wes_pkg::SEG_X2:    q = {off, 1'b0};
      wes_pkg::SEG_X3H:   q = off3[6:1];
      wes_pkg::SEG_X1:    q = {1'b0, off};
      wes_pkg::SEG_QUART: q = {3'b000, off[4:2]};
      default:            q = 6'd0;
    endcase
  end

  assign pct = pbase - {2'b00, q};

endmodule

`default_nettype wire

/* rtl/core/wes_div100.sv */
// Multiplies a scaled pulse width by the fixed-point reciprocal of 100.
// Depends on wes_pkg.
`default_nettype none

module wes_div100 (
  input  wire logic [wes_pkg::PROD_W-1:0]   prod,
  output logic [wes_pkg::SCALED_W-1:0]      scaled
);

  assign scaled = {{wes_pkg::RECIP_W{1'b0}}, prod} *
                  {{wes_pkg::PROD_W{1'b0}}, wes_pkg::RECIP_M};

endmodule

`default_nettype wire

/* rtl/core/wes_sat.sv */
// Finishes the divide by 100 with a shift and clamps the width to 16 bits.
// Depends on wes_pkg.
`default_nettype none

module wes_sat (
  input  wire logic [wes_pkg::SCALED_W-1:0] scaled,
  input  wire logic [wes_pkg::PCT_W-1:0]    pct,
  output wes_pkg::result_t                  res
);

  logic [wes_pkg::QUOT_W-1:0] quot;
  logic                       over;

  assign quot = scaled[wes_pkg::SCALED_W-1:wes_pkg::RECIP_SH];
  assign over = |quot[wes_pkg::QUOT_W-1:wes_pkg::PW_W];

  assign res.width = over ? wes_pkg::PW_MAX : quot[wes_pkg::PW_W-1:0];
  assign res.pct   = pct;
  assign res.sat   = over;

endmodule

`default_nettype wire

/* rtl/core/warmup_enrichment_scaler.sv */
// Top level of the warm-up enrichment scaler: four-stage pipeline with handshake.
// Depends on wes_pkg, wes_pct_calc, wes_div100 and wes_sat.
`default_nettype none

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+------------------------------------------
// input     | in        | in_valid/in_ready   | in_coolant_temp (s9), in_base_pulse_width
// result    | out       | out_valid/out_ready | out_enriched_pulse_width, out_enrich_percent,
//           |           |                     | out_width_saturated
//
// An accepted item passes in order through percentage lookup, width times percentage,
// multiply by the reciprocal of 100, then shift and saturate into the output register.
// One item can enter every cycle while out_ready keeps the pipeline moving.
// Each stage holds its item while the stage after it is full and stalled, so a stall at
// the output fills bubbles first and then backs up to in_ready.
// Reset clears only the valid bits; the data registers need no reset.

module warmup_enrichment_scaler (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [wes_pkg::TEMP_W-1:0]   in_coolant_temp,
  input  wire logic [wes_pkg::PW_W-1:0]            in_base_pulse_width,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [wes_pkg::PW_W-1:0]                 out_enriched_pulse_width,
  output logic [wes_pkg::PCT_W-1:0]                out_enrich_percent,
  output logic                                     out_width_saturated
);

  // Stage valid bits travel alongside the data.
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  // Stage 1: percentage and the untouched base width.
  logic [wes_pkg::PCT_W-1:0]    s1_pct_r, s1_pct_nxt;
  logic [wes_pkg::PW_W-1:0]     s1_base_r;
  // Stage 2: width times percentage, at most 65535 * 180.
  logic [wes_pkg::PROD_W-1:0]   s2_prod_r, s2_prod_nxt;
  logic [wes_pkg::PCT_W-1:0]    s2_pct_r;
  // Stage 3: product times the reciprocal of 100.
  logic [wes_pkg::SCALED_W-1:0] s3_scaled_r, s3_scaled_nxt;
  logic [wes_pkg::PCT_W-1:0]    s3_pct_r;
  // Output register.
  wes_pkg::result_t             out_res_r, out_res_nxt;

  // A stage can take a new item when it is empty or its item moves on this cycle.
  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy3     = !s3_valid_r || rdy_out;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;

  wes_pct_calc u_pct (
    .temp (in_coolant_temp),
    .pct  (s1_pct_nxt)
  );

  assign s2_prod_nxt = {{wes_pkg::PCT_W{1'b0}}, s1_base_r} *
                       {{wes_pkg::PW_W{1'b0}}, s1_pct_r};

  wes_div100 u_div (
    .prod   (s2_prod_r),
    .scaled (s3_scaled_nxt)
  );

  wes_sat u_sat (
    .scaled (s3_scaled_r),
    .pct    (s3_pct_r),
    .res    (out_res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    s1_valid_r  <= in_valid;
      if (rdy2)    s2_valid_r  <= s1_valid_r;
      if (rdy3)    s3_valid_r  <= s2_valid_r;
      if (rdy_out) out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_pct_r  <= s1_pct_nxt;
      s1_base_r <= in_base_pulse_width;
    end
    if (rdy2 && s1_valid_r) begin
      s2_prod_r <= s2_prod_nxt;
      s2_pct_r  <= s1_pct_r;
    end
    if (rdy3 && s2_valid_r) begin
      s3_scaled_r <= s3_scaled_nxt;
      s3_pct_r    <= s2_pct_r;
    end
    if (rdy_out && s3_valid_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_enriched_pulse_width = out_res_r.width;
  assign out_enrich_percent       = out_res_r.pct;
  assign out_width_saturated      = out_res_r.sat;

  // An accepted item always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted item did not reach stage 1");

  // The percentage always lies between the table ends.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_enrich_percent >= wes_pkg::P_K7 &&
                   out_enrich_percent <= wes_pkg::P_K0))
    else $error("enrichment percentage outside table range");

  // A saturated result is pinned at the maximum width.
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_width_saturated) |-> (out_enriched_pulse_width == wes_pkg::PW_MAX))
    else $error("saturated width not at maximum");

  // No enrichment can never overflow the width.
  a_no_sat_at_100: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_enrich_percent == wes_pkg::P_K7) |-> !out_width_saturated)
    else $error("saturation flagged at 100 percent");

  // A full stage 3 stalled behind a full output register keeps its item.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && out_valid_r && !out_ready) |=> s3_valid_r)
    else $error("stage 3 item lost during stall");

endmodule

`default_nettype wire
